// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the splat block checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset
`define SPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// property checked in the cycle after the antecedent, outside reset
`define SPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// property checked through reset as well
`define SPT_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// spt_pkg
// types, register codes and shading table of the torus point splatter
// ----------------------------------------------------------------------------
package spt_pkg;

    typedef struct packed {
        logic signed [15:0] cos_a;
        logic signed [15:0] sin_a;
        logic signed [15:0] cos_b;
        logic signed [15:0] sin_b;
        logic        [7:0]  frame_width;
        logic        [6:0]  frame_height;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_COS_A        = 3'd0,
        REG_SIN_A        = 3'd1,
        REG_COS_B        = 3'd2,
        REG_SIN_B        = 3'd3,
        REG_FRAME_WIDTH  = 3'd4,
        REG_FRAME_HEIGHT = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_PLOT = 2'd0,
        CMD_READ = 2'd1,
        CMD_NULL = 2'd2
    } t_cmd_kind;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_PROJ,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_RESOLVE
    } t_back_state;

    localparam logic [6:0]  GLYPH_SPACE = 7'h20;
    localparam logic [4:0]  MUL_LAST    = 5'd23;
    localparam logic [4:0]  DIV_LAST    = 5'd30;
    localparam logic [4:0]  PROJ_LAST   = 5'd3;
    localparam logic signed [25:0] Z_OFFSET = 26'sd81920;
    localparam logic signed [25:0] CX_OFFSET = 26'sd32768;

    function automatic logic [6:0] shade_glyph(input logic signed [25:0] lum);
        logic [14:0] sh;
        logic [3:0]  idx;
        sh  = lum[25:11];
        idx = (sh > 15'd11) ? 4'd11 : sh[3:0];
        case (idx)
            4'd0:    shade_glyph = 7'h2E;
            4'd1:    shade_glyph = 7'h2C;
            4'd2:    shade_glyph = 7'h2D;
            4'd3:    shade_glyph = 7'h7E;
            4'd4:    shade_glyph = 7'h3A;
            4'd5:    shade_glyph = 7'h3B;
            4'd6:    shade_glyph = 7'h3D;
            4'd7:    shade_glyph = 7'h21;
            4'd8:    shade_glyph = 7'h2A;
            4'd9:    shade_glyph = 7'h23;
            4'd10:   shade_glyph = 7'h24;
            default: shade_glyph = 7'h40;
        endcase
    endfunction

    // sum in units of 2^-33, truncated toward zero
    function automatic logic signed [22:0] trunc33(input logic signed [55:0] s);
        logic signed [55:0] t;
        t = s[55] ? (s + 56'sd8589934591) : s;
        trunc33 = t[55:33];
    endfunction

endpackage

// ===== design/spt_queue.sv =====
// ----------------------------------------------------------------------------
// spt_queue
// small command fifo between the geometry front and the pixel back
// ----------------------------------------------------------------------------
module spt_queue #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== design/spt_front.sv =====
// ----------------------------------------------------------------------------
// spt_front
// accepts items, rotates and projects torus samples, queues pixel commands
// ----------------------------------------------------------------------------
module spt_front import spt_pkg::*; #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    parameter int ADDR_W   = $clog2(MAX_COLS * MAX_ROWS),
    parameter int CMD_W    = 2 + ADDR_W + 16 + 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_enable,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_func,
    input  logic signed [15:0]       i_cos_theta,
    input  logic signed [15:0]       i_sin_theta,
    input  logic signed [15:0]       i_cos_phi,
    input  logic signed [15:0]       i_sin_phi,
    input  logic        [6:0]        i_pixel_col,
    input  logic        [5:0]        i_pixel_row,
    output logic                     o_push,
    output logic        [CMD_W-1:0]  o_cmd,
    input  logic                     i_full
);
    t_front_state r_state, n_state;

    logic [4:0]         r_step, n_step;
    logic signed [25:0] r_ct, r_st, r_cp, r_sp, r_cx;
    logic signed [25:0] n_ct, n_st, n_cp, n_sp, n_cx;
    logic signed [25:0] r_t0, r_t1, r_x, r_y, r_z, r_l;
    logic signed [25:0] n_t0, n_t1, n_x, n_y, n_z, n_l;
    logic [25:0]        r_rem, n_rem;
    logic [30:0]        r_quo, n_quo;
    logic [15:0]        r_ooz, n_ooz;
    logic signed [51:0] r_wp, n_wp;
    logic signed [22:0] r_col, r_row, n_col, n_row;

    logic signed [25:0] ca, sa, cb, sb;
    logic signed [25:0] mul_a, mul_b, m_q;
    logic signed [51:0] m_full;
    logic [26:0]        trial, zc;
    logic               accept, z_pos, hit;
    logic [ADDR_W-1:0]  rd_addr, pl_addr;
    logic               rd_in_range;

    assign ca = {{10{i_cfg.cos_a[15]}}, i_cfg.cos_a};
    assign sa = {{10{i_cfg.sin_a[15]}}, i_cfg.sin_a};
    assign cb = {{10{i_cfg.cos_b[15]}}, i_cfg.cos_b};
    assign sb = {{10{i_cfg.sin_b[15]}}, i_cfg.sin_b};

    assign accept = i_valid && o_ready;
    assign z_pos  = !r_z[25] && (r_z != '0);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            F_MUL: begin
                case (r_step)
                    5'd0:    begin mul_a = cb;   mul_b = r_cp; end
                    5'd1:    begin mul_a = sa;   mul_b = sb;   end
                    5'd2:    begin mul_a = r_t1; mul_b = r_sp; end
                    5'd3:    begin mul_a = r_cx; mul_b = r_t0; end
                    5'd4:    begin mul_a = ca;   mul_b = sb;   end
                    5'd5:    begin mul_a = r_st; mul_b = r_t1; end
                    5'd6:    begin mul_a = sb;   mul_b = r_cp; end
                    5'd7:    begin mul_a = sa;   mul_b = cb;   end
                    5'd8:    begin mul_a = r_t1; mul_b = r_sp; end
                    5'd9:    begin mul_a = r_cx; mul_b = r_t0; end
                    5'd10:   begin mul_a = ca;   mul_b = cb;   end
                    5'd11:   begin mul_a = r_st; mul_b = r_t1; end
                    5'd12:   begin mul_a = ca;   mul_b = r_cx; end
                    5'd13:   begin mul_a = r_t0; mul_b = r_sp; end
                    5'd14:   begin mul_a = r_st; mul_b = sa;   end
                    5'd15:   begin mul_a = r_cp; mul_b = r_ct; end
                    5'd16:   begin mul_a = r_t0; mul_b = sb;   end
                    5'd17:   begin mul_a = ca;   mul_b = r_ct; end
                    5'd18:   begin mul_a = r_t0; mul_b = r_sp; end
                    5'd19:   begin mul_a = sa;   mul_b = r_st; end
                    5'd20:   begin mul_a = ca;   mul_b = r_st; end
                    5'd21:   begin mul_a = r_ct; mul_b = sa;   end
                    5'd22:   begin mul_a = r_t1; mul_b = r_sp; end
                    default: begin mul_a = cb;   mul_b = r_t0; end
                endcase
            end
            F_PROJ: begin
                case (r_step)
                    5'd0:    begin mul_a = {18'b0, i_cfg.frame_width}; mul_b = {10'b0, r_ooz}; end
                    5'd1:    begin mul_a = r_t0; mul_b = r_x; end
                    default: begin mul_a = r_t0; mul_b = r_y; end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign m_full = mul_a * mul_b;
    assign m_q    = m_full[39:14];

    assign trial = {r_rem, (r_step == 5'd0)};
    assign zc    = {1'b0, r_z};

    assign hit = !r_col[22] && (r_col[21:0] < 22'(i_cfg.frame_width))
              && (r_col[21:0] < 22'(MAX_COLS))
              && !r_row[22] && (r_row[21:0] < 22'(i_cfg.frame_height))
              && (r_row[21:0] < 22'(MAX_ROWS))
              && !r_l[25] && (r_l != '0);

    assign rd_in_range = (32'(i_pixel_col) < MAX_COLS) && (32'(i_pixel_row) < MAX_ROWS);
    assign rd_addr = ADDR_W'(i_pixel_row) * ADDR_W'(MAX_COLS) + ADDR_W'(i_pixel_col);
    assign pl_addr = ADDR_W'(r_row[21:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(r_col[21:0]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept && !i_func) begin
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                if (r_step == MUL_LAST) begin
                    n_state = z_pos ? F_DIV : F_IDLE;
                end
            end
            F_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_state = F_PROJ;
                end
            end
            F_PROJ: begin
                if (r_step == PROJ_LAST) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!hit || !i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_step = r_step;
        n_ct = r_ct; n_st = r_st; n_cp = r_cp; n_sp = r_sp; n_cx = r_cx;
        n_t0 = r_t0; n_t1 = r_t1; n_x = r_x; n_y = r_y; n_z = r_z; n_l = r_l;
        n_rem = r_rem; n_quo = r_quo; n_ooz = r_ooz;
        n_wp = r_wp; n_col = r_col; n_row = r_row;
        case (r_state)
            F_IDLE: begin
                n_step = '0;
                if (accept && !i_func) begin
                    n_ct = 26'(i_cos_theta);
                    n_st = 26'(i_sin_theta);
                    n_cp = 26'(i_cos_phi);
                    n_sp = 26'(i_sin_phi);
                    n_cx = CX_OFFSET + 26'(i_cos_theta);
                end
            end
            F_MUL: begin
                n_step = (r_step == MUL_LAST) ? 5'd0 : r_step + 5'd1;
                n_rem  = '0;
                n_quo  = '0;
                case (r_step)
                    5'd0, 5'd6, 5'd12, 5'd15, 5'd17, 5'd20: n_t0 = m_q;
                    5'd1, 5'd4, 5'd7, 5'd10, 5'd21:         n_t1 = m_q;
                    5'd2:    n_t0 = r_t0 + m_q;
                    5'd8:    n_t0 = r_t0 - m_q;
                    5'd22:   n_t0 = r_t0 - m_q;
                    5'd3:    n_x  = m_q;
                    5'd5:    n_x  = r_x - m_q;
                    5'd9:    n_y  = m_q;
                    5'd11:   n_y  = r_y + m_q;
                    5'd13:   n_z  = Z_OFFSET + m_q;
                    5'd14:   n_z  = r_z + m_q;
                    5'd16:   n_l  = m_q;
                    5'd18:   n_l  = r_l - m_q;
                    5'd19:   n_l  = r_l - m_q;
                    default: n_l  = r_l + m_q;
                endcase
            end
            F_DIV: begin
                n_step = (r_step == DIV_LAST) ? 5'd0 : r_step + 5'd1;
                if (trial >= zc) begin
                    n_rem = 26'(trial - zc);
                    n_quo = {r_quo[29:0], 1'b1};
                end else begin
                    n_rem = trial[25:0];
                    n_quo = {r_quo[29:0], 1'b0};
                end
                n_ooz = (|n_quo[30:16]) ? 16'hFFFF : n_quo[15:0];
            end
            F_PROJ: begin
                n_step = r_step + 5'd1;
                case (r_step)
                    5'd0: n_t0 = m_full[25:0];
                    5'd1: n_wp = m_full;
                    5'd2: begin
                        n_col = trunc33({16'b0, i_cfg.frame_width[7:1], 33'b0}
                                        + {{4{r_wp[51]}}, r_wp});
                        n_wp  = m_full;
                    end
                    default: n_row = trunc33({17'b0, i_cfg.frame_height[6:1], 33'b0}
                                             - {{4{r_wp[51]}}, r_wp});
                endcase
            end
            default: n_step = '0;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            F_IDLE: begin
                o_ready = i_enable && !i_full;
                if (accept && i_func) begin
                    o_push = 1'b1;
                    o_cmd  = {rd_in_range ? CMD_READ : CMD_NULL, rd_addr, 16'b0, GLYPH_SPACE};
                end
            end
            F_PUSH: begin
                o_push = hit && !i_full;
                o_cmd  = {CMD_PLOT, pl_addr, r_ooz, shade_glyph(r_l)};
            end
            default: begin
                o_ready = 1'b0;
                o_push  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ct <= n_ct; r_st <= n_st; r_cp <= n_cp; r_sp <= n_sp; r_cx <= n_cx;
        r_t0 <= n_t0; r_t1 <= n_t1; r_x <= n_x; r_y <= n_y; r_z <= n_z; r_l <= n_l;
        r_rem <= n_rem; r_quo <= n_quo; r_ooz <= n_ooz;
        r_wp <= n_wp; r_col <= n_col; r_row <= n_row;
    end

endmodule

// ===== design/spt_back.sv =====
// ----------------------------------------------------------------------------
// spt_back
// pixel store: depth test and write for plots, read and clear for reads, empty pixel for null reads
// ----------------------------------------------------------------------------
module spt_back import spt_pkg::*; #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    parameter int ADDR_W   = $clog2(MAX_COLS * MAX_ROWS),
    parameter int CMD_W    = 2 + ADDR_W + 16 + 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic [CMD_W-1:0]  i_cmd,
    output logic              o_cleared,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [6:0]        o_glyph,
    output logic [15:0]       o_depth
);
    localparam int PIX_COUNT = MAX_COLS * MAX_ROWS;

    t_back_state r_state, n_state;

    logic [22:0]       r_mem [PIX_COUNT];
    logic [22:0]       r_rdata;
    logic [CMD_W-1:0]  r_cmd;
    logic [ADDR_W-1:0] r_clr;
    logic              r_out_valid, n_out_valid;
    logic [6:0]        r_glyph, n_glyph;
    logic [15:0]       r_depth, n_depth;

    t_cmd_kind         kind;
    logic [ADDR_W-1:0] addr, in_addr;
    logic [15:0]       ooz;
    logic [6:0]        glyph;
    logic              out_free, clr_last;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [22:0]       wdata;

    assign kind    = t_cmd_kind'(r_cmd[CMD_W-1 -: 2]);
    assign addr    = r_cmd[ADDR_W+22:23];
    assign ooz     = r_cmd[22:7];
    assign glyph   = r_cmd[6:0];
    assign in_addr = i_cmd[ADDR_W+22:23];

    assign out_free = !r_out_valid || i_ready;
    assign clr_last = (r_clr == ADDR_W'(PIX_COUNT - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: begin
                if (clr_last) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = B_RESOLVE;
                end
            end
            B_RESOLVE: begin
                if (kind == CMD_PLOT || out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = 1'b0;
        we          = 1'b0;
        waddr       = addr;
        wdata       = {GLYPH_SPACE, 16'b0};
        n_out_valid = r_out_valid && !i_ready;
        n_glyph     = r_glyph;
        n_depth     = r_depth;
        case (r_state)
            B_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
            end
            B_IDLE: begin
                o_pop = !i_empty;
            end
            B_RESOLVE: begin
                case (kind)
                    CMD_PLOT: begin
                        we    = (ooz > r_rdata[15:0]);
                        wdata = {glyph, ooz};
                    end
                    CMD_READ: begin
                        if (out_free) begin
                            we          = 1'b1;
                            n_out_valid = 1'b1;
                            n_glyph     = r_rdata[22:16];
                            n_depth     = r_rdata[15:0];
                        end
                    end
                    default: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_glyph     = GLYPH_SPACE;
                            n_depth     = '0;
                        end
                    end
                endcase
            end
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph <= n_glyph;
        r_depth <= n_depth;
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (o_pop) begin
            r_rdata <= r_mem[in_addr];
        end
    end

    assign o_cleared = (r_state != B_CLEAR);
    assign o_valid   = r_out_valid;
    assign o_glyph   = r_glyph;
    assign o_depth   = r_depth;

endmodule

// ===== design/torus_point_splat_zbuffer_top.sv =====
// ----------------------------------------------------------------------------
// torus_point_splat_zbuffer_top
// spinning torus point splatter with a depth-tested character frame store
//
//   port group   direction  handshake         payload
//   sample/read  in         i_valid/o_ready   i_func, angles, pixel col/row
//   pixel        out        o_valid/i_ready   o_glyph, o_depth
//   config       in         psel/penable      paddr, pwdata, prdata
//
// a plot passes the front in 24 steps of one shared multiplier,
// 31 steps of a bit-serial 1/z divider, 4 projection steps, the queue push
// and the idle state that takes the next transaction
// a read is queued in the cycle it is accepted; the back does a single-port
// store read-modify-write per command in an idle state (pop, read) and a
// resolve state (write); after reset the store is swept empty, no items taken
// meanwhile; the command queue lets the front run while the output stalls
// ----------------------------------------------------------------------------
module torus_point_splat_zbuffer_top import spt_pkg::*; #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic signed [15:0] i_cos_theta,
    input  logic signed [15:0] i_sin_theta,
    input  logic signed [15:0] i_cos_phi,
    input  logic signed [15:0] i_sin_phi,
    input  logic        [6:0]  i_pixel_col,
    input  logic        [5:0]  i_pixel_row,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [6:0]  o_glyph,
    output logic        [15:0] o_depth,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);
    localparam int ADDR_W = $clog2(MAX_COLS * MAX_ROWS);
    localparam int CMD_W  = 2 + ADDR_W + 16 + 7;

    t_cfg             r_cfg;
    t_reg_idx         reg_idx;
    logic             cfg_wr;
    logic             push, pop, full, empty, cleared;
    logic [CMD_W-1:0] push_cmd, pop_cmd;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_a        <= 16'sd16384;
            r_cfg.sin_a        <= '0;
            r_cfg.cos_b        <= 16'sd16384;
            r_cfg.sin_b        <= '0;
            r_cfg.frame_width  <= 8'd80;
            r_cfg.frame_height <= 7'd24;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_COS_A:        r_cfg.cos_a        <= pwdata[15:0];
                REG_SIN_A:        r_cfg.sin_a        <= pwdata[15:0];
                REG_COS_B:        r_cfg.cos_b        <= pwdata[15:0];
                REG_SIN_B:        r_cfg.sin_b        <= pwdata[15:0];
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[7:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COS_A:        prdata = {{16{r_cfg.cos_a[15]}}, r_cfg.cos_a};
            REG_SIN_A:        prdata = {{16{r_cfg.sin_a[15]}}, r_cfg.sin_a};
            REG_COS_B:        prdata = {{16{r_cfg.cos_b[15]}}, r_cfg.cos_b};
            REG_SIN_B:        prdata = {{16{r_cfg.sin_b[15]}}, r_cfg.sin_b};
            REG_FRAME_WIDTH:  prdata = {24'b0, r_cfg.frame_width};
            REG_FRAME_HEIGHT: prdata = {25'b0, r_cfg.frame_height};
            default:          prdata = '0;
        endcase
    end

    spt_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .ADDR_W   (ADDR_W),
        .CMD_W    (CMD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_enable    (cleared),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_cos_theta (i_cos_theta),
        .i_sin_theta (i_sin_theta),
        .i_cos_phi   (i_cos_phi),
        .i_sin_phi   (i_sin_phi),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (full)
    );

    spt_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (empty)
    );

    spt_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .ADDR_W   (ADDR_W),
        .CMD_W    (CMD_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .o_pop     (pop),
        .i_cmd     (pop_cmd),
        .o_cleared (cleared),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_glyph   (o_glyph),
        .o_depth   (o_depth)
    );

endmodule

// ===== design/spt_checker.sv =====
// ----------------------------------------------------------------------------
// spt_checker
// port-level checks of the torus point splatter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [6:0]  o_glyph,
    input logic [15:0] o_depth,
    input logic        pready
);
    `SPT_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")
    `SPT_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_glyph) && $stable(o_depth), "stalled pixel changed")
    `SPT_ASSERT_NOW(a_empty_pixel, o_valid, (o_depth == 16'd0) == (o_glyph == 7'h20), "glyph and depth disagree on empty pixel")
    `SPT_ASSERT_RST(a_reset_idle, !i_rst_n, !o_valid && !o_ready, "activity right after reset")
endmodule

bind torus_point_splat_zbuffer_top spt_checker u_spt_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Tests the torus point splatter and its depth-tested character frame store.
// Plot samples are run through a fixed-point model of the rotation, the
// projection and the depth test. Pixel reads are checked field by field
// against the oldest predicted pixel. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb import spt_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOLS = 128;
    localparam int NROWS = 64;
    localparam int STORE_LAT = 100;
    localparam string SHADES = ".,-~:;=!*#$@";

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_func;
    logic signed [15:0] i_cos_theta;
    logic signed [15:0] i_sin_theta;
    logic signed [15:0] i_cos_phi;
    logic signed [15:0] i_sin_phi;
    logic        [6:0]  i_pixel_col;
    logic        [5:0]  i_pixel_row;
    logic               o_valid;
    logic               i_ready;
    logic        [6:0]  o_glyph;
    logic        [15:0] o_depth;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic        [4:0]  paddr;
    logic        [31:0] pwdata;
    logic        [31:0] prdata;
    logic               pready;

    torus_point_splat_zbuffer_top #(.MAX_COLS(NCOLS), .MAX_ROWS(NROWS)) DUT (.*);

    typedef struct packed {
        logic [6:0]  glyph;
        logic [15:0] depth;
    } t_pixel;

    logic [6:0]  glyph_mem [NCOLS*NROWS];
    logic [15:0] depth_mem [NCOLS*NROWS];
    t_cfg        cfg;
    t_pixel      pixel_q[$];
    int          mismatches;
    int          reads_seen;
    int          plots_sent;
    bit          stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint fmul(longint a, longint b);
        longint p;
        p = a * b;
        if (p >= 0) return p >>> 14;
        return -((-p + 16383) >>> 14);
    endfunction

    function automatic longint div_trunc(longint n, longint d);
        longint q;
        q = (n < 0 ? -n : n) / d;
        return n < 0 ? -q : q;
    endfunction

    task automatic predict_plot(input longint ct, st, cp, sp);
        longint ca, sa, cb, sb, cx, cy, x, y, z, lum, ooz, col, row, w, h, sh;
        int idx;
        ca = cfg.cos_a; sa = cfg.sin_a; cb = cfg.cos_b; sb = cfg.sin_b;
        w = cfg.frame_width; h = cfg.frame_height;
        cx = 32768 + ct; cy = st;
        x = fmul(cx, fmul(cb, cp) + fmul(fmul(sa, sb), sp)) - fmul(cy, fmul(ca, sb));
        y = fmul(cx, fmul(sb, cp) - fmul(fmul(sa, cb), sp)) + fmul(cy, fmul(ca, cb));
        z = 81920 + fmul(fmul(ca, cx), sp) + fmul(cy, sa);
        lum = fmul(fmul(cp, ct), sb) - fmul(fmul(ca, ct), sp) - fmul(sa, st)
            + fmul(cb, fmul(ca, st) - fmul(fmul(ct, sa), sp));
        if (z <= 0) return;
        ooz = (64'sd1 <<< 30) / z;
        if (ooz > 65535) ooz = 65535;
        col = div_trunc((w / 2) * (64'sd1 <<< 33) + w * ooz * x, 64'sd1 <<< 33);
        row = div_trunc((h / 2) * (64'sd1 <<< 33) - w * ooz * y, 64'sd1 <<< 33);
        if (col < 0 || col >= w || col >= NCOLS) return;
        if (row < 0 || row >= h || row >= NROWS) return;
        if (lum <= 0) return;
        idx = int'(row * NCOLS + col);
        if (ooz > depth_mem[idx]) begin
            sh = lum >>> 11;
            if (sh > 11) sh = 11;
            depth_mem[idx] = ooz[15:0];
            glyph_mem[idx] = 7'(SHADES[int'(sh)]);
        end
    endtask

    task automatic send_item(input logic func, input logic [15:0] ct, st, cp, sp,
                             input logic [6:0] col, input logic [5:0] row);
        i_valid     <= 1'b1;
        i_func      <= func;
        i_cos_theta <= ct;
        i_sin_theta <= st;
        i_cos_phi   <= cp;
        i_sin_phi   <= sp;
        i_pixel_col <= col;
        i_pixel_row <= row;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (func == CMD_PLOT[0]) begin
            plots_sent++;
            predict_plot($signed(ct), $signed(st), $signed(cp), $signed(sp));
        end else begin
            if (col < NCOLS && row < NROWS) begin
                pixel_q.push_back({glyph_mem[row*NCOLS+col], depth_mem[row*NCOLS+col]});
                glyph_mem[row*NCOLS+col] = GLYPH_SPACE;
                depth_mem[row*NCOLS+col] = '0;
            end else begin
                pixel_q.push_back({GLYPH_SPACE, 16'd0});
            end
        end
    endtask

    task automatic gap_maybe();
        int n;
        if ($urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            n = $urandom_range(1, 6);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (STORE_LAT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_COS_A:        cfg.cos_a = v[15:0];
            REG_SIN_A:        cfg.sin_a = v[15:0];
            REG_COS_B:        cfg.cos_b = v[15:0];
            REG_SIN_B:        cfg.sin_b = v[15:0];
            REG_FRAME_WIDTH:  cfg.frame_width = v[7:0];
            REG_FRAME_HEIGHT: cfg.frame_height = v[6:0];
            default: ;
        endcase
    endtask

    task automatic set_angles(input int ca, sa, cb, sb);
        write_reg(REG_COS_A, ca);
        write_reg(REG_SIN_A, sa);
        write_reg(REG_COS_B, cb);
        write_reg(REG_SIN_B, sb);
    endtask

    function automatic logic [15:0] unit_val();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 16'($urandom());
        if (r == 1) return 16'sd16384;
        if (r == 2) return -16'sd16384;
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // scan a window of the frame
    task automatic read_frame(input int c0, input int r0, input int w, input int h);
        for (int r = r0; r < r0 + h && r < NROWS; r++)
            for (int c = c0; c < c0 + w && c < NCOLS; c++) begin
                gap_maybe();
                send_item(CMD_READ[0], 16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()), 7'(c), 6'(r));
            end
    endtask

    // reads spread at random over the whole store
    task automatic read_spread(input int n);
        for (int k = 0; k < n; k++) begin
            gap_maybe();
            send_item(CMD_READ[0], 16'($urandom()), 16'($urandom()), 16'($urandom()),
                      16'($urandom()), 7'($urandom()), 6'($urandom()));
        end
    endtask

    task automatic test_directed();
        logic [15:0] edge_v [5];
        edge_v = '{16'h4000, 16'hC000, 16'h0000, 16'h7FFF, 16'h8000};
        send_item(CMD_READ[0], 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0, 6'd0);
        send_item(CMD_READ[0], 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd127, 6'd63);
        // typical front view, then a tie on the same point
        for (int k = 0; k < 2; k++)
            send_item(CMD_PLOT[0], 16'h0000, 16'hC000, 16'h4000, 16'h0000, 7'd0, 6'd0);
        send_item(CMD_PLOT[0], 16'h4000, 16'h0000, 16'h0000, 16'hC000, 7'd0, 6'd0);
        foreach (edge_v[i])
            send_item(CMD_PLOT[0], edge_v[i], edge_v[(i+1)%5], edge_v[(i+2)%5],
                      edge_v[(i+3)%5], 7'd0, 6'd0);
        // points behind the viewer
        send_item(CMD_PLOT[0], 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 7'd0, 6'd0);
        send_item(CMD_PLOT[0], 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 7'd0, 6'd0);
        drain();
        read_frame(24, 6, 32, 12);
        drain();
    endtask

    task automatic test_random_phase(input int ca, sa, cb, sb, w, h, n);
        int cols, rows;
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        set_angles(ca, sa, cb, sb);
        cols = (w == 0) ? 1 : w;
        rows = (h == 0) ? 1 : h;
        for (int k = 0; k < n; k++) begin
            gap_maybe();
            if ($urandom_range(0, 3) == 0)
                send_item(CMD_READ[0], 16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()),
                          $urandom_range(0, 2) == 0 ? 7'($urandom())
                                                    : 7'($urandom_range(0, cols-1)),
                          $urandom_range(0, 2) == 0 ? 6'($urandom())
                                                    : 6'($urandom_range(0, rows-1)));
            else
                send_item(CMD_PLOT[0], unit_val(), unit_val(), unit_val(), unit_val(),
                          7'd0, 6'd0);
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_func = 1'b0;
        i_cos_theta = '0; i_sin_theta = '0; i_cos_phi = '0; i_sin_phi = '0;
        i_pixel_col = '0; i_pixel_row = '0; i_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; reads_seen = 0; plots_sent = 0;
        cfg = '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 8'd80, 7'd24};
        for (int i = 0; i < NCOLS*NROWS; i++) begin
            glyph_mem[i] = GLYPH_SPACE;
            depth_mem[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(16384, 0, 16384, 0, 80, 24, 200);
        test_random_phase(11585, 11585, 0, 16384, 128, 64, 200);
        test_random_phase(-16384, 0, 0, -16384, 8, 4, 150);
        test_random_phase(-11585, -11585, 11585, -11585, 255, 127, 150);
        test_random_phase(16384, 16384, 16384, 16384, 1, 1, 80);
        test_random_phase(8192, 14189, 14189, 8192, 0, 10, 60);
        test_random_phase(-32768, 32767, 32767, -32768, 40, 0, 60);
        test_random_phase(14189, -8192, -8192, 14189, 60, 30, 120);
        read_spread(200);
        drain();
        $display("ran %0d plot samples and %0d pixel reads over 8 rotation/frame settings",
                 plots_sent, reads_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stall pattern: alternates busy and free stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        i_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    initial stall_mode = 1'b0;

    always @(posedge i_clk) begin
        t_pixel exp_px;
        if (i_rst_n && o_valid && i_ready) begin
            reads_seen++;
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel transaction glyph %h depth %h", o_glyph, o_depth);
            end else begin
                exp_px = pixel_q.pop_front();
                if (exp_px.glyph !== o_glyph || exp_px.depth !== o_depth) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected glyph %h depth %h, got %h %h",
                                 exp_px.glyph, exp_px.depth, o_glyph, o_depth);
                end
            end
        end
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/spt_pkg.sv
design/spt_queue.sv
design/spt_front.sv
design/spt_back.sv
design/torus_point_splat_zbuffer_top.sv
design/spt_checker.sv
test/tb.sv
